@@ rtl/core/steq_pkg.sv @@
// Shared types and constants of the sorted timer event queue.
package steq_pkg;

   // Result status codes.
   localparam logic [1:0] STATUS_ADDED   = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_EXPIRED = 2'd2;
   localparam logic [1:0] STATUS_NONE    = 2'd3;

   // Request kinds carried on the input tuser.
   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Most expiries reported by one tick.
   localparam int MAX_RESULTS = 16;
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

   // One stored timer.
   typedef struct packed {
      logic [31:0] due;
      logic [7:0]  handler;
      logic [31:0] argument;
   } entry_type;

endpackage

@@ rtl/core/steq_entry_ram.sv @@
// Timer entry memory: one write port and one registered read port.
module steq_entry_ram
   import steq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int PTR_W       = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PTR_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [PTR_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sorted_timer_event_queue_core.sv @@
// Top level of the sorted timer event queue: sequencer, ring pointers and output register.
//
// Usage: the req channel takes one item at a time. tuser selects add (0) or tick (1).
// An add computes its due time as uptime plus delay and is inserted after every
// entry with an equal or earlier due time; it gives one result, status added or,
// when the queue holds QUEUE_DEPTH entries, status full. A tick advances the
// uptime by one second and reports every due entry in order (at most 16), the
// final one flagged by tlast, or a single nothing-due result.
// Entries live in a ring in a memory with one write port and one registered read
// port; popping only moves the head. Insertion walks back from the tail; for each
// entry it moves it does one memory read, then one compare and write. A tick reads
// each head entry from the memory and then compares its due time with the uptime.
// The block is ready again as soon as its last result sits in the output
// register, so a stalled receiver delays at most one item. When the receiver
// stalls, results wait in the output register and the sequencer waits with them.
// Reset empties the queue and clears the uptime; memory contents need no clearing.
module sorted_timer_event_queue_core
   import steq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // handler_id[7:0], handler_arg[39:8], delay_seconds[55:40]
   input  logic [0:0]  req_tuser,  // req_type[0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // out_handler_id[7:0], out_handler_arg[39:8], due_time[71:40]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   output logic        rsp_tlast
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [NRES_W-1:0] NRES_MAX = NRES_W'(MAX_RESULTS);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_I_RD  = 3'd1;
   localparam logic [2:0] ST_I_CMP = 3'd2;
   localparam logic [2:0] ST_T_RD  = 3'd3;
   localparam logic [2:0] ST_T_CMP = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  handler;
      logic [31:0] argument;
      logic [31:0] due;
   } result_type;

   logic [2:0]        state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       uptime_ff, uptime_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  walk_ff, walk_in;
   logic [NRES_W-1:0] nres_ff, nres_in;
   result_type        hold_ff, hold_in;
   logic              hold_valid_ff, hold_valid_in;
   entry_type         new_ff, new_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_accept;
   logic              out_free;
   logic [CNT_W:0]    tail_sum;
   logic [PTR_W-1:0]  tail_idx;
   logic [PTR_W-1:0]  ptr_prev;
   logic [PTR_W-1:0]  head_next;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   entry_type         wr_data;
   logic              rd_en;
   logic [PTR_W-1:0]  rd_addr;
   entry_type         rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Ring index arithmetic.
   assign tail_sum  = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
   assign tail_idx  = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                    ? PTR_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                    : PTR_W'(tail_sum);
   assign ptr_prev  = (ptr_ff == '0) ? LAST_IDX : ptr_ff - 1'b1;
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;

   steq_entry_ram #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PTR_W       (PTR_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: insertion walk, expiry walk and result staging.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      uptime_in     = uptime_ff;
      ptr_in        = ptr_ff;
      walk_in       = walk_ff;
      nres_in       = nres_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      new_in        = new_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = new_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_prev;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser[0] == REQ_TICK) begin
                  uptime_in     = uptime_ff + 32'd1;
                  nres_in       = '0;
                  hold_valid_in = 1'b0;
                  state_in      = ST_T_RD;
               end else if (count_ff == FULL_CNT) begin
                  hold_in  = '{status: STATUS_FULL, handler: '0, argument: '0, due: '0};
                  state_in = ST_EMIT;
               end else begin
                  new_in.due      = uptime_ff + 32'(req_tdata[55:40]);
                  new_in.handler  = req_tdata[7:0];
                  new_in.argument = req_tdata[39:8];
                  ptr_in          = tail_idx;
                  walk_in         = count_ff;
                  state_in        = ST_I_RD;
               end
            end
         end

         // Either place the new entry here or fetch the entry below.
         ST_I_RD: begin
            if (walk_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               hold_in  = '{status: STATUS_ADDED, handler: '0, argument: '0, due: new_ff.due};
               state_in = ST_EMIT;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_I_CMP;
            end
         end

         // A later entry moves up one slot; otherwise the new entry lands here.
         ST_I_CMP: begin
            wr_en = 1'b1;
            if (rd_data.due > new_ff.due) begin
               wr_data  = rd_data;
               ptr_in   = ptr_prev;
               walk_in  = walk_ff - 1'b1;
               state_in = ST_I_RD;
            end else begin
               count_in = count_ff + 1'b1;
               hold_in  = '{status: STATUS_ADDED, handler: '0, argument: '0, due: new_ff.due};
               state_in = ST_EMIT;
            end
         end

         // Fetch the head unless the queue is empty or the tick is at its limit.
         ST_T_RD: begin
            rd_addr = head_ff;
            if ((count_ff == '0) || (nres_ff == NRES_MAX)) begin
               if (!hold_valid_ff) begin
                  hold_in = '{status: STATUS_NONE, handler: '0, argument: '0, due: '0};
               end
               state_in = ST_EMIT;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_T_CMP;
            end
         end

         // A due head is popped into the hold register, pushing the previous one out.
         ST_T_CMP: begin
            if (uptime_ff >= rd_data.due) begin
               if (!hold_valid_ff || out_free) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = hold_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_in       = '{status: STATUS_EXPIRED, handler: rd_data.handler,
                                    argument: rd_data.argument, due: rd_data.due};
                  hold_valid_in = 1'b1;
                  head_in       = head_next;
                  count_in      = count_ff - 1'b1;
                  nres_in       = nres_ff + 1'b1;
                  state_in      = ST_T_RD;
               end
            end else begin
               if (!hold_valid_ff) begin
                  hold_in = '{status: STATUS_NONE, handler: '0, argument: '0, due: '0};
               end
               state_in = ST_EMIT;
            end
         end

         // The final result of the item goes out with tlast set.
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = hold_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         uptime_ff     <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         uptime_ff     <= uptime_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      walk_ff     <= walk_in;
      nres_ff     <= nres_in;
      hold_ff     <= hold_in;
      new_ff      <= new_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.due, rsp_ff.argument, rsp_ff.handler};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_last_ff;

endmodule
